@@ sv/ldc_pkg.sv @@
// package: types, constants and exp table for the linear discriminant classifier
package ldc_pkg;

   localparam int MAX_CLASSES     = 16;
   localparam int MAX_FEATURES    = 16;
   localparam int EXP_TABLE_DEPTH = 256;
   localparam int ROW_LEN         = MAX_FEATURES + 1;
   localparam int CLS_W  = $clog2(MAX_CLASSES);
   localparam int FEAT_W = $clog2(MAX_FEATURES);
   localparam int CNT_W  = $clog2(MAX_FEATURES + 2);
   localparam int WADDR_W = $clog2(MAX_CLASSES * ROW_LEN);
   localparam int EIDX_W = $clog2(EXP_TABLE_DEPTH);
   localparam int EXP_SHIFT = 20 - EIDX_W;
   localparam int SUM_W  = 33 + CLS_W + 1;

   localparam logic [1:0] FUNC_WEIGHT  = 2'd0;
   localparam logic [1:0] FUNC_LABEL   = 2'd1;
   localparam logic [1:0] FUNC_FEATURE = 2'd2;
   localparam logic [1:0] FUNC_NONE    = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_MODEL = 2'd1;
   localparam logic [1:0] ST_COUNT    = 2'd2;

   localparam logic [1:0] REG_CLASS_COUNT   = 2'd0;
   localparam logic [1:0] REG_FEATURE_COUNT = 2'd1;
   localparam logic [1:0] REG_MODEL_VALID   = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_MAC_RD, S_MAC, S_SCORE, S_EXP, S_DIV_INIT, S_DIV,
      S_EMIT, S_ERR
   } state_type;

   // e^(-16/depth) as a 13 term taylor series in q32, floored terms
   localparam longint unsigned EXP_H   = (64'd16 << 32) / EXP_TABLE_DEPTH;
   localparam longint unsigned EXP_T1  = EXP_H;
   localparam longint unsigned EXP_T2  = ((EXP_T1 * EXP_H) >> 32) / 64'd2;
   localparam longint unsigned EXP_T3  = ((EXP_T2 * EXP_H) >> 32) / 64'd3;
   localparam longint unsigned EXP_T4  = ((EXP_T3 * EXP_H) >> 32) / 64'd4;
   localparam longint unsigned EXP_T5  = ((EXP_T4 * EXP_H) >> 32) / 64'd5;
   localparam longint unsigned EXP_T6  = ((EXP_T5 * EXP_H) >> 32) / 64'd6;
   localparam longint unsigned EXP_T7  = ((EXP_T6 * EXP_H) >> 32) / 64'd7;
   localparam longint unsigned EXP_T8  = ((EXP_T7 * EXP_H) >> 32) / 64'd8;
   localparam longint unsigned EXP_T9  = ((EXP_T8 * EXP_H) >> 32) / 64'd9;
   localparam longint unsigned EXP_T10 = ((EXP_T9 * EXP_H) >> 32) / 64'd10;
   localparam longint unsigned EXP_T11 = ((EXP_T10 * EXP_H) >> 32) / 64'd11;
   localparam longint unsigned EXP_T12 = ((EXP_T11 * EXP_H) >> 32) / 64'd12;
   localparam longint unsigned EXP_RATIO = (64'd1 << 32) - EXP_T1 + EXP_T2 - EXP_T3
                                           + EXP_T4 - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8
                                           - EXP_T9 + EXP_T10 - EXP_T11 + EXP_T12;

   typedef logic [32:0] exp_tab_type [EXP_TABLE_DEPTH];

   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      longint unsigned r, v;
      logic [127:0] p;
      r = EXP_RATIO;
      v = 64'd1 << 32;
      tab[0] = 33'(v);
      for (int i = 1; i < EXP_TABLE_DEPTH; i++) begin
         p = 128'(v) * 128'(r) + (128'd1 << 31);
         v = 64'(p >> 32);
         tab[i] = 33'(v);
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

@@ sv/linear_discriminant_classifier_core.sv @@
// top level: linear discriminant classifier with table exp and softmax normalization
// Weight, label and feature words are taken one per cycle while idle. The word marked
// last_feature starts a run: for each class one multiply-accumulate per feature on a single
// shared 32x32 multiplier (one weight memory read port), then one table exp per class, then
// a restoring divider per class for the likelihood (the winner's first, so every row can
// carry it). Each row leaves as soon as its division is done and the output register is free,
// and req_stall is high for the whole run. A run with an error gives one status row.
module linear_discriminant_classifier_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_class_slot,
   input  logic [4:0]  req_coeff_slot,
   input  logic signed [31:0] req_value,
   input  logic        req_last_feature,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_result_class,
   output logic signed [31:0] rsp_score,
   output logic [16:0] rsp_likelihood,
   output logic [15:0] rsp_predicted_label,
   output logic [16:0] rsp_best_likelihood,
   output logic        rsp_final_row,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);

   localparam int CW = ldc_pkg::CLS_W;
   localparam int FW = ldc_pkg::FEAT_W;
   localparam int NW = ldc_pkg::CNT_W;
   localparam int AW = ldc_pkg::WADDR_W;
   localparam int SW = ldc_pkg::SUM_W;
   localparam int QW = 17 + SW;

   ldc_pkg::state_type state_ff, state_in;

   logic [4:0] class_count_ff, feature_count_ff;
   logic       model_valid_ff;

   logic signed [31:0] wmem [ldc_pkg::MAX_CLASSES * ldc_pkg::ROW_LEN];
   logic [15:0]        lmem [ldc_pkg::MAX_CLASSES];
   logic signed [31:0] fbuf [ldc_pkg::MAX_FEATURES];
   logic signed [31:0] sbuf [ldc_pkg::MAX_CLASSES];
   logic [32:0]        ebuf [ldc_pkg::MAX_CLASSES];

   logic [NW-1:0] seen_ff;
   logic [CW:0]   nc_ff;
   logic [CW-1:0] k_ff, k_in, best_ff;
   logic [NW-1:0] j_ff, j_in;
   logic signed [31:0] wrd_ff, max_ff;
   logic signed [33:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic [SW-1:0] sum_ff;
   logic [QW-1:0] rem_ff, num_ff;
   logic [16:0]   quo_ff, bestlik_ff;
   logic [5:0]    dcnt_ff;
   logic          bestdone_ff;
   logic [15:0]   blabel_ff;

   // output register
   logic        ov_ff;
   logic [1:0]  ost_ff;
   logic [3:0]  ocls_ff;
   logic signed [31:0] oscore_ff;
   logic [16:0] olik_ff;
   logic [15:0] blabel_out_ff;
   logic [16:0] obest_ff;
   logic        ofin_ff;

   logic accept;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ldc_pkg::S_IDLE);

   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr;
   assign waddr = AW'(req_class_slot) * AW'(ldc_pkg::ROW_LEN) + AW'(req_coeff_slot);
   assign raddr = AW'(k_ff) * AW'(ldc_pkg::ROW_LEN) + AW'(j_ff);

   logic [NW-1:0] j_prev;
   assign j_prev = j_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (accept && req_func == ldc_pkg::FUNC_WEIGHT &&
          32'(req_coeff_slot) <= 32'(ldc_pkg::MAX_FEATURES))
         wmem[waddr] <= req_value;
      if (accept && req_func == ldc_pkg::FUNC_LABEL)
         lmem[req_class_slot] <= req_value[15:0];
      if (accept && req_func == ldc_pkg::FUNC_FEATURE &&
          32'(seen_ff) < 32'(ldc_pkg::MAX_FEATURES))
         fbuf[seen_ff[FW-1:0]] <= req_value;
      wrd_ff <= wmem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= 5'd1;
         feature_count_ff <= 5'd1;
         model_valid_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            ldc_pkg::REG_CLASS_COUNT:   class_count_ff <= csr_data;
            ldc_pkg::REG_FEATURE_COUNT: feature_count_ff <= csr_data;
            ldc_pkg::REG_MODEL_VALID:   model_valid_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [NW-1:0] seen_next;
   assign seen_next = (32'(seen_ff) <= 32'(ldc_pkg::MAX_FEATURES)) ? seen_ff + 1'b1 : seen_ff;
   logic count_bad;
   assign count_bad = feature_count_ff == 5'd0 ||
                      32'(feature_count_ff) > 32'(ldc_pkg::MAX_FEATURES) ||
                      32'(seen_next) != 32'(feature_count_ff);

   logic signed [48:0] sum_acc;
   logic signed [31:0] sat_acc;
   logic signed [63:0] fl;
   assign fl = prod_ff >>> 16;
   assign sum_acc = 49'(acc_ff) + 49'(fl);
   always_comb begin
      if (sum_acc > 49'sd2147483647) sat_acc = 32'sh7fffffff;
      else if (sum_acc < -49'sd2147483648) sat_acc = 32'sh80000000;
      else sat_acc = sum_acc[31:0];
   end

   logic [32:0] xdiff;
   logic [32:0] eval;
   assign xdiff = 33'(34'(max_ff) - 34'(sbuf[k_ff]));
   always_comb begin
      if (xdiff[32:20] != '0) eval = '0;
      else eval = ldc_pkg::EXP_TAB[xdiff[19:ldc_pkg::EXP_SHIFT]];
   end

   logic [QW:0] rem_sh;
   logic [QW:0] rem_sub;
   assign rem_sh = {rem_ff, num_ff[QW-1]};
   assign rem_sub = rem_sh - (QW+1)'(sum_ff);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ldc_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      j_in = j_ff;
      case (state_ff)
         ldc_pkg::S_IDLE:
            if (accept && req_func == ldc_pkg::FUNC_FEATURE && req_last_feature) begin
               if (!model_valid_ff || count_bad) state_in = ldc_pkg::S_ERR;
               else begin
                  state_in = ldc_pkg::S_MAC_RD;
                  k_in = '0;
                  j_in = '0;
               end
            end
         ldc_pkg::S_MAC_RD: state_in = ldc_pkg::S_MAC;
         ldc_pkg::S_MAC: begin
            j_in = j_ff + 1'b1;
            state_in = (32'(j_ff) == 32'(feature_count_ff)) ? ldc_pkg::S_SCORE
                                                             : ldc_pkg::S_MAC_RD;
         end
         ldc_pkg::S_SCORE: begin
            j_in = '0;
            if (32'(k_ff) + 32'(1) == 32'(nc_ff)) begin
               k_in = '0;
               state_in = ldc_pkg::S_EXP;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = ldc_pkg::S_MAC_RD;
            end
         end
         ldc_pkg::S_EXP:
            if (32'(k_ff) + 32'(1) == 32'(nc_ff)) begin
               k_in = '0;
               state_in = ldc_pkg::S_DIV_INIT;
            end else k_in = k_ff + 1'b1;
         ldc_pkg::S_DIV_INIT: state_in = ldc_pkg::S_DIV;
         ldc_pkg::S_DIV:
            if (dcnt_ff == 6'(QW - 1)) state_in = ldc_pkg::S_EMIT;
         ldc_pkg::S_EMIT:
            if (!ov_ff || !rsp_stall) begin
               if (!bestdone_ff) state_in = ldc_pkg::S_DIV_INIT;
               else if (32'(k_ff) + 32'(1) == 32'(nc_ff)) state_in = ldc_pkg::S_IDLE;
               else begin
                  k_in = k_ff + 1'b1;
                  state_in = ldc_pkg::S_DIV_INIT;
               end
            end
         ldc_pkg::S_ERR:
            if (!ov_ff || !rsp_stall) state_in = ldc_pkg::S_IDLE;
         default: state_in = ldc_pkg::S_IDLE;
      endcase
   end

   logic out_free;
   assign out_free = !ov_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      j_ff <= j_in;
      case (state_ff)
         ldc_pkg::S_IDLE: begin
            nc_ff <= (class_count_ff == 5'd0) ? (CW+1)'(1) :
                     (32'(class_count_ff) > 32'(ldc_pkg::MAX_CLASSES)) ?
                     (CW+1)'(ldc_pkg::MAX_CLASSES) : (CW+1)'(class_count_ff);
            best_ff <= '0;
            sum_ff <= '0;
            bestdone_ff <= 1'b0;
         end
         ldc_pkg::S_MAC: begin
            if (j_ff == '0) acc_ff <= 34'(wrd_ff);
            else acc_ff <= 34'(sat_acc);
            if (j_ff != '0)
               prod_ff <= 64'(fbuf[j_prev[FW-1:0]]) * 64'(wrd_ff);
            else prod_ff <= '0;
         end
         ldc_pkg::S_SCORE: begin
            sbuf[k_ff] <= sat_acc;
            if (k_ff == '0 || sat_acc > max_ff) begin
               best_ff <= k_ff;
               max_ff <= sat_acc;
            end
         end
         ldc_pkg::S_EXP: begin
            ebuf[k_ff] <= eval;
            sum_ff <= sum_ff + SW'(eval);
            blabel_ff <= lmem[best_ff];
         end
         ldc_pkg::S_DIV_INIT: begin
            rem_ff <= '0;
            num_ff <= QW'({(bestdone_ff ? ebuf[k_ff] : ebuf[best_ff]), 16'd0})
                      + QW'(sum_ff >> 1);
            dcnt_ff <= '0;
         end
         ldc_pkg::S_DIV: begin
            num_ff <= {num_ff[QW-2:0], 1'b0};
            dcnt_ff <= dcnt_ff + 1'b1;
            if (!rem_sub[QW]) begin
               rem_ff <= rem_sub[QW-1:0];
               quo_ff <= {quo_ff[15:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[QW-1:0];
               quo_ff <= {quo_ff[15:0], 1'b0};
            end
         end
         ldc_pkg::S_EMIT:
            if (out_free && !bestdone_ff) begin
               bestdone_ff <= 1'b1;
               bestlik_ff <= quo_ff;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) seen_ff <= '0;
      else if (accept && req_func == ldc_pkg::FUNC_FEATURE)
         seen_ff <= req_last_feature ? '0 : seen_next;
   end

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (out_free)
         ov_ff <= (state_ff == ldc_pkg::S_ERR) ||
                  (state_ff == ldc_pkg::S_EMIT && bestdone_ff);
   end

   logic [1:0] err_code;
   logic err_q;
   always_ff @(posedge clock) begin
      if (state_ff == ldc_pkg::S_IDLE && accept)
         err_q <= !model_valid_ff;
   end
   assign err_code = err_q ? ldc_pkg::ST_NO_MODEL : ldc_pkg::ST_COUNT;

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (state_ff == ldc_pkg::S_ERR) begin
            ost_ff <= err_code;
            ocls_ff <= '0;
            oscore_ff <= '0;
            olik_ff <= '0;
            blabel_out_ff <= '0;
            obest_ff <= '0;
            ofin_ff <= 1'b1;
         end else begin
            ost_ff <= ldc_pkg::ST_OK;
            ocls_ff <= 4'(k_ff);
            oscore_ff <= sbuf[k_ff];
            olik_ff <= quo_ff;
            blabel_out_ff <= blabel_ff;
            obest_ff <= bestlik_ff;
            ofin_ff <= 32'(k_ff) + 32'(1) == 32'(nc_ff);
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_status = ost_ff;
   assign rsp_result_class = ocls_ff;
   assign rsp_score = oscore_ff;
   assign rsp_likelihood = olik_ff;
   assign rsp_predicted_label = blabel_out_ff;
   assign rsp_best_likelihood = obest_ff;
   assign rsp_final_row = ofin_ff;

endmodule

@@ sv/ldc_checker.sv @@
// checker: port level properties of the classifier core, bound to the top level
module ldc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_func,
   input logic        req_last_feature,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [16:0] rsp_likelihood,
   input logic        rsp_final_row
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled word changed");

   a_lik_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_likelihood <= 17'd65536)
      else $error("likelihood out of range");

   a_err_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ldc_pkg::ST_OK |-> rsp_final_row)
      else $error("error word not final");

   a_run_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == ldc_pkg::FUNC_FEATURE && req_last_feature
      |=> req_stall)
      else $error("input not stalled during run");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind linear_discriminant_classifier_core ldc_checker u_ldc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_func(req_func), .req_last_feature(req_last_feature),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_likelihood(rsp_likelihood), .rsp_final_row(rsp_final_row)
);
